>>> design/decimal96_integer_rounding_defines.svh
// Assertion macros shared by the decimal96 rounding modules.
`ifndef DECIMAL96_INTEGER_ROUNDING_DEFINES_SVH
`define DECIMAL96_INTEGER_ROUNDING_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define D96_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define D96_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/d96rnd_pkg.sv
// Types and constants of the decimal96 integer rounding unit.
package d96rnd_pkg;

  localparam int WORD_W    = 32;
  localparam int MAG_WORDS = 3;
  localparam int MAG_W     = WORD_W * MAG_WORDS;
  localparam int SCALE_W   = 5;
  localparam int REM_W     = 4;
  localparam int WIDX_W    = 2;

  // Word index of the most significant magnitude word.
  localparam logic [WIDX_W-1:0] TOP_WORD = 2'd2;
  localparam logic [WIDX_W-1:0] LOW_WORD = 2'd0;

  // floor(x / 5) = (x * RECIP5) >> RECIP5_SHIFT for any 32-bit x.
  localparam logic [WORD_W-1:0] RECIP5       = 32'hCCCC_CCCD;
  localparam int                RECIP5_SHIFT = 34;
  // 2^32 = 10 * DIV10_K + 6
  localparam logic [WORD_W-1:0] DIV10_K      = 32'd429496729;
  localparam logic [REM_W-1:0]  ROUND_HALF   = 4'd5;

  typedef enum logic [1:0] {
    OP_NEGATE   = 2'd0,
    OP_TRUNCATE = 2'd1,
    OP_FLOOR    = 2'd2,
    OP_ROUND    = 2'd3
  } opcode_e;

  typedef struct packed {
    opcode_e             opcode;
    logic [WORD_W-1:0]   mantissa_low;
    logic [WORD_W-1:0]   mantissa_mid;
    logic [WORD_W-1:0]   mantissa_high;
    logic [SCALE_W-1:0]  scale_in;
    logic                sign_in;
  } in_word_t;

  typedef struct packed {
    logic [WORD_W-1:0]   out_mantissa_low;
    logic [WORD_W-1:0]   out_mantissa_mid;
    logic [WORD_W-1:0]   out_mantissa_high;
    logic [SCALE_W-1:0]  scale_out;
    logic                sign_out;
  } out_word_t;

  // Controller to datapath.
  typedef struct packed {
    logic              load;
    logic              step;
    logic              finish;
    logic [WIDX_W-1:0] widx;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic [SCALE_W-1:0] digits;
  } status_t;

endpackage

>>> design/d96rnd_ctrl.sv
// Sequencer of the decimal96 rounding unit: digit and word counters.
`include "decimal96_integer_rounding_defines.svh"

module d96rnd_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  d96rnd_pkg::status_t  status_i,
  output d96rnd_pkg::cmd_t     cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_PREP = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_FIN  = 4'b1000
  } state_e;

  state_e                              state_q, state_d;
  logic [d96rnd_pkg::SCALE_W-1:0]      digits_q, digits_d;
  logic [d96rnd_pkg::WIDX_W-1:0]       widx_q, widx_d;

  always_comb begin
    state_d     = state_q;
    digits_d    = digits_q;
    widx_d      = widx_q;
    cmd_o       = '0;
    cmd_o.widx  = widx_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = ST_PREP;
        end
      end
      ST_PREP: begin
        digits_d = status_i.digits;
        widx_d   = d96rnd_pkg::TOP_WORD;
        state_d  = (status_i.digits == '0) ? ST_FIN : ST_DIV;
      end
      ST_DIV: begin
        cmd_o.step = 1'b1;
        if (widx_q == d96rnd_pkg::LOW_WORD) begin
          widx_d   = d96rnd_pkg::TOP_WORD;
          digits_d = digits_q - d96rnd_pkg::SCALE_W'(1);
          if (digits_q == d96rnd_pkg::SCALE_W'(1)) begin
            state_d = ST_FIN;
          end
        end else begin
          widx_d = widx_q - d96rnd_pkg::WIDX_W'(1);
        end
      end
      ST_FIN: begin
        cmd_o.finish = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      digits_q <= '0;
      widx_q   <= '0;
    end else begin
      state_q  <= state_d;
      digits_q <= digits_d;
      widx_q   <= widx_d;
    end
  end

  assign busy = (state_q != ST_IDLE);

  `D96_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy, "accepted word not busy")
  `D96_ASSERT_IMPL(a_div_digits, clk_i, rst_ni, state_q == ST_DIV, digits_q != '0, "div with no digits")
  `D96_ASSERT_NEXT(a_fin_idle, clk_i, rst_ni, state_q == ST_FIN, !busy, "finish not followed by idle")

endmodule

>>> design/d96rnd_dpath.sv
// Datapath of the decimal96 rounding unit: magnitude, word divider, result register.
`include "decimal96_integer_rounding_defines.svh"

module d96rnd_dpath #(
  parameter int MAX_SCALE = 28
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  d96rnd_pkg::in_word_t   in_word_i,
  input  d96rnd_pkg::cmd_t       cmd_i,
  output d96rnd_pkg::status_t    status_o,
  output d96rnd_pkg::out_word_t  result_o,
  output logic                   done_o
);

  localparam int unsigned SW = d96rnd_pkg::SCALE_W;
  localparam logic [SW-1:0] ScaleLim = SW'(MAX_SCALE);

  logic [d96rnd_pkg::MAG_WORDS-1:0][d96rnd_pkg::WORD_W-1:0] mag_q;
  logic [d96rnd_pkg::REM_W-1:0]   rem_q, last_q;
  logic                           any_q;
  d96rnd_pkg::opcode_e            op_q;
  logic [SW-1:0]                  scale_q;
  logic                           sign_q;
  d96rnd_pkg::out_word_t          result_q;
  logic                           done_q;

  logic [SW-1:0]                  scale_sat;
  logic [d96rnd_pkg::WORD_W-1:0]  word_sel, q5, hi_part, quot;
  logic [d96rnd_pkg::REM_W-1:0]   rem_in, rem_new;
  logic [6:0]                     rem6;
  logic [d96rnd_pkg::WORD_W:0]    npart, rem10;
  logic [2*d96rnd_pkg::WORD_W-1:0] prod;
  logic                           inc, is_neg_op;
  logic [d96rnd_pkg::MAG_W-1:0]   mag_res;

  assign scale_sat = (in_word_i.scale_in > ScaleLim) ? ScaleLim : in_word_i.scale_in;

  assign is_neg_op       = (op_q == d96rnd_pkg::OP_NEGATE);
  assign status_o.digits = is_neg_op ? '0 : scale_q;

  // One word of the long division by ten: (rem * 2^32 + w) / 10
  // = rem * K + (w + 6 * rem) / 10, the last part done as (x / 2) / 5.
  assign word_sel = mag_q[cmd_i.widx];
  assign rem_in   = (cmd_i.widx == d96rnd_pkg::TOP_WORD) ? '0 : rem_q;
  assign rem6     = 7'({rem_in, 2'b00}) + 7'({rem_in, 1'b0});
  assign npart    = {1'b0, word_sel} + 33'(rem6);
  assign prod     = 64'(npart[d96rnd_pkg::WORD_W:1]) * 64'(d96rnd_pkg::RECIP5);
  assign q5       = 32'(prod[2*d96rnd_pkg::WORD_W-1:d96rnd_pkg::RECIP5_SHIFT]);
  assign rem10    = npart - ((33'(q5) << 3) + (33'(q5) << 1));
  assign rem_new  = rem10[d96rnd_pkg::REM_W-1:0];
  assign hi_part  = 32'(32'(rem_in) * d96rnd_pkg::DIV10_K);
  assign quot     = hi_part + q5;

  assign inc = ((op_q == d96rnd_pkg::OP_FLOOR) && sign_q && any_q) ||
               ((op_q == d96rnd_pkg::OP_ROUND) && (last_q >= d96rnd_pkg::ROUND_HALF));
  assign mag_res = mag_q + d96rnd_pkg::MAG_W'(inc);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mag_q   <= {in_word_i.mantissa_high, in_word_i.mantissa_mid, in_word_i.mantissa_low};
      op_q    <= in_word_i.opcode;
      scale_q <= scale_sat;
      sign_q  <= in_word_i.sign_in;
      rem_q   <= '0;
      last_q  <= '0;
      any_q   <= 1'b0;
    end else if (cmd_i.step) begin
      mag_q[cmd_i.widx] <= quot;
      rem_q             <= rem_new;
      if (cmd_i.widx == d96rnd_pkg::LOW_WORD) begin
        last_q <= rem_new;
        any_q  <= any_q | (rem_new != '0);
      end
    end
    if (cmd_i.finish) begin
      result_q.out_mantissa_low  <= mag_res[d96rnd_pkg::WORD_W-1:0];
      result_q.out_mantissa_mid  <= mag_res[2*d96rnd_pkg::WORD_W-1:d96rnd_pkg::WORD_W];
      result_q.out_mantissa_high <= mag_res[d96rnd_pkg::MAG_W-1:2*d96rnd_pkg::WORD_W];
      result_q.scale_out         <= is_neg_op ? scale_q : '0;
      result_q.sign_out          <= is_neg_op ? ~sign_q : sign_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.finish;
    end
  end

  assign result_o = result_q;
  assign done_o   = done_q;

  `D96_ASSERT_NEXT(a_strobe_single, clk_i, rst_ni, done_q, !done_q, "result strobe held")
  `D96_ASSERT_IMPL(a_int_scale, clk_i, rst_ni, done_q && !is_neg_op, result_q.scale_out == '0, "nonzero scale after rounding")

endmodule

>>> design/decimal96_integer_rounding.sv
// Top level of the decimal96 integer rounding unit (negate, truncate, floor, round).
// Each accepted word passes prepare, s digit passes and finish, then done_o rises, where s is
//   the saturated scale for truncate/floor/round and 0 for negate.
// No new word is accepted while busy; each decimal digit passes the three 32-bit magnitude words,
//   one at a time, through a single divide-by-ten unit (32x32 reciprocal mult).
// Reset: rst_ni asynchronous active low; clears the sequencer and the strobe, the unit idles.
// The receiver cannot stall: each result is valid on result_o in the single cycle done_o is high.

module decimal96_integer_rounding #(
  parameter int MAX_SCALE = 28
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  d96rnd_pkg::in_word_t   in_word_i,
  output d96rnd_pkg::out_word_t  result_o,
  output logic                   done_o
);

  // Command and status between sequencer and datapath.
  d96rnd_pkg::cmd_t    cmd;
  d96rnd_pkg::status_t status;

  // Sequencer: idle -> prepare (load digit count) -> divide (one pass over the three words per digit) -> finish.
  d96rnd_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .status_i (status),
    .cmd_o    (cmd)
  );

  // Datapath: magnitude register, word divider by ten, increment and result register.
  d96rnd_dpath #(
    .MAX_SCALE (MAX_SCALE)
  ) u_dpath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_word_i (in_word_i),
    .cmd_i     (cmd),
    .status_o  (status),
    .result_o  (result_o),
    .done_o    (done_o)
  );

endmodule
